[hdl/chained_hash_table_unit_defines.svh]
// Assertion macros for the chained hash table unit.
`ifndef CHAINED_HASH_TABLE_UNIT_DEFINES_SVH
`define CHAINED_HASH_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define CHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cht assertion failed");
`define CHT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cht assertion failed");
`else
`define CHT_ASSERT(lbl, prop)
`define CHT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[hdl/cht_pkg.sv]
`default_nettype none
package cht_pkg;

  localparam int unsigned KEY_W     = 31;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned MOD_STEPS = 3;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic ACT_SET = 1'b0;
  localparam logic ACT_GET = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic mod_step;
    logic rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[hdl/chained_hash_table_unit.sv]
`default_nettype none
// Key-value store of BUCKETS buckets with up to WAYS entries each; a key
// lands in bucket key mod BUCKETS. A set (action 0) appends key and value to
// the bucket and flags collision when it already held entries, or is refused
// with full_res when it holds WAYS. A get (action 1) returns the newest
// matching value with hit, or -1 on a miss. After reset the block clears the
// bucket fill counts, one bucket a cycle, before it takes the first word.
// Each word then passes from acceptance to the next acceptance through these
// steps in order: accept, the modulo unit (reciprocal multiply for a quotient
// estimate, multiply back, subtract and correct), a bucket row read, and a
// compare of all ways with write back. The result word sits in an output
// register, so the next word can be accepted while it waits; a result that is
// ready while that register is still held waits with the input until the held
// word is taken.
module chained_hash_table_unit
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS = 997,
  parameter int unsigned WAYS    = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    action_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic signed [VAL_W-1:0] value_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic signed [VAL_W-1:0] value_out_o,
  output logic                    collision_o,
  output logic                    full_res_o
);

  cmd_t cmd;
  sts_t sts;

  cht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cht_dpath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (action_i),
    .key_i       (key_i),
    .value_in_i  (value_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .value_out_o (value_out_o),
    .collision_o (collision_o),
    .full_res_o  (full_res_o)
  );

endmodule
`default_nettype wire

[hdl/cht_ctrl.sv]
`default_nettype none
module cht_ctrl
  import cht_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/cht_mod.sv]
`default_nettype none
module cht_mod
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS = 997,
  parameter int unsigned BW      = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             step_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             last_o,
  output logic [BW-1:0]    rem_o
);

  localparam int unsigned      PW      = 2 * KEY_W;
  localparam int unsigned      QW      = KEY_W + BW + 1;
  localparam longint unsigned  RECIP_L = (64'd1 << KEY_W) / BUCKETS;
  localparam logic [KEY_W-1:0] RECIP   = RECIP_L[KEY_W-1:0];
  localparam logic [BW:0]      BUCK_W  = BUCKETS[BW:0];

  logic [MOD_CNT_W-1:0] cnt_q;
  logic [PW-1:0]        prod;
  logic [QW-1:0]        qd;
  logic [KEY_W-1:0]     quo_q, qd_q, diff;
  logic [BW:0]          r_raw;
  logic [BW-1:0]        rem_q, rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + MOD_CNT_W'(1);
    end
  end

  // estimate the quotient by reciprocal, multiply back, subtract and correct once
  assign prod = PW'(key_i) * PW'(RECIP);
  assign qd   = QW'(quo_q) * QW'(BUCK_W);
  assign diff = key_i - qd_q;

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      quo_q <= prod[PW-1:KEY_W];
      qd_q  <= qd[KEY_W-1:0];
      rem_q <= rem_d;
    end
  end

  always_comb begin
    r_raw = diff[BW:0];
    if (r_raw >= BUCK_W) begin
      r_raw = r_raw - BUCK_W;
    end
    rem_d = r_raw[BW-1:0];
  end

  assign last_o = (cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

[hdl/cht_dpath.sv]
`default_nettype none
`include "chained_hash_table_unit_defines.svh"
module cht_dpath
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS = 997,
  parameter int unsigned WAYS    = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic                    action_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic signed [VAL_W-1:0] value_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic signed [VAL_W-1:0] value_out_o,
  output logic                    collision_o,
  output logic                    full_res_o
);

  localparam int unsigned BW   = $clog2(BUCKETS);
  localparam int unsigned FW   = $clog2(WAYS + 1);
  localparam int unsigned WIDX = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic                 act_q;
  logic [KEY_W-1:0]     key_q;
  logic [VAL_W-1:0]     val_q;
  logic [BW-1:0]        bkt;
  logic                 mod_last;
  logic [BW-1:0]        clr_q;

  logic [FW-1:0]        fill_mem_q [BUCKETS];
  logic [KEY_W-1:0]     key_mem_q  [BUCKETS][WAYS];
  logic [VAL_W-1:0]     val_mem_q  [BUCKETS][WAYS];

  logic [FW-1:0]        fill_rd_q;
  logic [KEY_W-1:0]     key_row_q  [WAYS];
  logic [VAL_W-1:0]     val_row_q  [WAYS];

  logic                 full, coll, ghit, wr_en;
  logic [VAL_W-1:0]     gval;
  logic [WIDX-1:0]      widx;

  logic                 out_valid_q;
  logic                 hit_q, coll_q, full_q;
  logic [VAL_W-1:0]     value_q;

  cht_mod #(
    .BUCKETS (BUCKETS),
    .BW      (BW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .step_i  (cmd_i.mod_step),
    .key_i   (key_q),
    .last_o  (mod_last),
    .rem_o   (bkt)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      key_q <= key_i;
      val_q <= value_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + BW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      fill_mem_q[clr_q] <= '0;
    end else if (wr_en) begin
      fill_mem_q[bkt] <= fill_rd_q + FW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem_q[bkt][widx] <= key_q;
      val_mem_q[bkt][widx] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      fill_rd_q <= fill_mem_q[bkt];
      key_row_q <= key_mem_q[bkt];
      val_row_q <= val_mem_q[bkt];
    end
  end

  always_comb begin
    full = (fill_rd_q >= FW'(WAYS));
    coll = (fill_rd_q != '0);
    widx = fill_rd_q[WIDX-1:0];
    ghit = 1'b0;
    gval = '1;
    for (int w = 0; w < WAYS; w++) begin
      if ((FW'(w) < fill_rd_q) && (key_row_q[w] == key_q)) begin
        ghit = 1'b1;
        gval = val_row_q[w];
      end
    end
    wr_en = cmd_i.commit && (act_q == ACT_SET) && !full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (act_q == ACT_SET) begin
        hit_q   <= !full;
        value_q <= '1;
        coll_q  <= coll;
        full_q  <= full;
      end else begin
        hit_q   <= ghit;
        value_q <= gval;
        coll_q  <= 1'b0;
        full_q  <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last = (clr_q == BW'(BUCKETS - 1));
  assign sts_o.mod_last = mod_last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign value_out_o = value_q;
  assign collision_o = coll_q;
  assign full_res_o  = full_q;

  `CHT_ASSERT(a_commit_shows_word, cmd_i.commit |=> out_valid_q)
  `CHT_ASSERT(a_bucket_in_range, cmd_i.rd |-> ({1'b0, bkt} < (BW + 1)'(BUCKETS)))
  `CHT_ASSERT(a_full_flags, (out_valid_q && full_q) |-> (coll_q && !hit_q))

endmodule
`default_nettype wire

[tb/hash_table_checker.sv]
`timescale 1ns / 100ps
module hash_table_checker
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS = 997,
  parameter int unsigned WAYS    = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_o,
  input  logic                    action_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic signed [VAL_W-1:0] value_in_i,
  input  logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  logic                    hit_o,
  input  logic signed [VAL_W-1:0] value_out_o,
  input  logic                    collision_o,
  input  logic                    full_res_o,
  output int unsigned             errors,
  output int unsigned             words_due,
  output int unsigned             found_seen,
  output int unsigned             collisions_seen,
  output int unsigned             refused_seen
);

  localparam int unsigned SLOTS = BUCKETS * WAYS;

  typedef struct packed {
    logic             is_get;
    logic             hit;
    logic [VAL_W-1:0] value;
    logic             collision;
    logic             full;
  } reply_t;

  int unsigned      bucket_fill [BUCKETS];
  logic [KEY_W-1:0] slot_key    [SLOTS];
  logic [VAL_W-1:0] slot_value  [SLOTS];
  reply_t           replies_due [$];

  initial begin
    errors          = 0;
    words_due       = 0;
    found_seen      = 0;
    collisions_seen = 0;
    refused_seen    = 0;
  end

  function automatic reply_t store_or_lookup(input logic act, input logic [KEY_W-1:0] k,
                                             input logic [VAL_W-1:0] v);
    reply_t      r;
    int unsigned b;
    int unsigned base;
    int unsigned fill;
    b    = k % BUCKETS;
    base = b * WAYS;
    fill = bucket_fill[b];
    r    = '{is_get: act, hit: 1'b0, value: '1, collision: 1'b0, full: 1'b0};
    if (act == ACT_SET) begin
      r.collision = (fill > 0);
      if (fill >= WAYS) begin
        r.full = 1'b1;
      end else begin
        slot_key[base + fill]   = k;
        slot_value[base + fill] = v;
        bucket_fill[b]          = fill + 1;
        r.hit                   = 1'b1;
      end
    end else begin
      for (int i = int'(fill) - 1; i >= 0; i--) begin
        if (slot_key[base + i] == k) begin
          r.hit   = 1'b1;
          r.value = slot_value[base + i];
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] got,
                               input logic [VAL_W-1:0] want);
    if (errors < 20) begin
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      foreach (bucket_fill[i]) bucket_fill[i] = 0;
      replies_due.delete();
      words_due = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("unexpected word", value_out_o, '1);
        end else begin
          want = replies_due.pop_front();
          if (hit_o !== want.hit) flag_mismatch("hit", VAL_W'(hit_o), VAL_W'(want.hit));
          if (value_out_o !== want.value) flag_mismatch("value_out", value_out_o, want.value);
          if (collision_o !== want.collision) begin
            flag_mismatch("collision", VAL_W'(collision_o), VAL_W'(want.collision));
          end
          if (full_res_o !== want.full) begin
            flag_mismatch("full_res", VAL_W'(full_res_o), VAL_W'(want.full));
          end
          if (want.is_get && want.hit) found_seen++;
          if (want.collision) collisions_seen++;
          if (want.full) refused_seen++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        replies_due.push_back(store_or_lookup(action_i, key_i, value_in_i));
      end
      words_due = replies_due.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
module testbench;
  import cht_pkg::*;

  localparam int unsigned BUCKETS     = 997;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_WORDS = 480;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    action_i;
  logic [KEY_W-1:0]        key_i;
  logic signed [VAL_W-1:0] value_in_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    hit_o;
  logic signed [VAL_W-1:0] value_out_o;
  logic                    collision_o;
  logic                    full_res_o;

  int unsigned errors;
  int unsigned words_due;
  int unsigned found_seen;
  int unsigned collisions_seen;
  int unsigned refused_seen;

  bit               steady;
  int unsigned      stall_cycles;
  int unsigned      sets_sent;
  int unsigned      gets_sent;
  logic [KEY_W-1:0] keys_written [$];

  chained_hash_table_unit #(.BUCKETS(BUCKETS), .WAYS(WAYS)) dut (.*);

  hash_table_checker #(.BUCKETS(BUCKETS), .WAYS(WAYS)) checker_inst (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i = steady || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved in %0d cycles", STALL_LIMIT);
        $display("chained_hash_table_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic send_word(input logic act, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
    if (!steady && $urandom_range(99) < 15) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i   = act;
    key_i      = k;
    value_in_i = v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (act == ACT_SET) begin
      sets_sent++;
      keys_written.push_back(k);
    end else begin
      gets_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (words_due != 0) @(negedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] key_in_bucket(input int unsigned b);
    int unsigned m;
    m = $urandom_range((32'h7FFF_FFFF - b) / BUCKETS);
    return KEY_W'(b + m * BUCKETS);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '1;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input int unsigned reuse_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < reuse_pct && keys_written.size() != 0) begin
      return keys_written[$urandom_range(keys_written.size() - 1)];
    end else if (r < reuse_pct + 25) begin
      return key_in_bucket($urandom_range(40));
    end else if (r < reuse_pct + 30) begin
      return key_in_bucket(BUCKETS - 1 - $urandom_range(2));
    end
    return KEY_W'($urandom());
  endfunction

  initial begin
    logic act;
    in_valid_i   = 1'b0;
    action_i     = ACT_SET;
    key_i        = '0;
    value_in_i   = '0;
    out_ready_i  = 1'b0;
    steady       = 1'b0;
    stall_cycles = 0;
    sets_sent    = 0;
    gets_sent    = 0;
    rst_ni       = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(ACT_GET, 31'd0, 32'h1234_5678);
    send_word(ACT_SET, 31'd0, 32'h7FFF_FFFF);
    send_word(ACT_SET, 31'd997, 32'h8000_0000);
    send_word(ACT_SET, 31'd0, 32'hFFFF_FFFF);
    send_word(ACT_GET, 31'd0, '0);
    send_word(ACT_GET, 31'd997, '0);
    send_word(ACT_SET, 31'd1994, 32'd5);
    send_word(ACT_SET, 31'd2991, 32'd6);
    send_word(ACT_SET, 31'd0, 32'd7);
    send_word(ACT_GET, 31'd2991, '0);
    send_word(ACT_GET, 31'd1994, '1);
    send_word(ACT_SET, 31'h7FFF_FFFF, '0);
    send_word(ACT_GET, 31'h7FFF_FFFF, '0);
    send_word(ACT_GET, 31'h7FFF_FFFF - 31'd997, '0);
    send_word(ACT_SET, 31'd1, 32'h5555_5555);
    send_word(ACT_SET, 31'd998, 32'hAAAA_AAAA);
    send_word(ACT_GET, 31'd1, '0);
    send_word(ACT_GET, 31'd998, '0);
    send_word(ACT_SET, 31'h2AAA_AAAA, 32'h0000_0001);
    send_word(ACT_GET, 31'h2AAA_AAAA, '0);
    send_word(ACT_GET, 31'h5555_5555, '0);
    wait_drained();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 150 && i < 300);
      if (i == 320) wait_drained();
      act = $urandom_range(1) ? ACT_GET : ACT_SET;
      if (act == ACT_SET) begin
        send_word(act, pick_key(15), pick_value());
      end else begin
        send_word(act, pick_key(60), $urandom());
      end
    end
    steady = 1'b0;
    wait_drained();
    repeat (30) @(posedge clk_i);

    $display("sent %0d sets and %0d gets; %0d lookups found their key", sets_sent,
             gets_sent, found_seen);
    $display("%0d sets landed in occupied buckets, %0d were refused on full buckets",
             collisions_seen, refused_seen);
    if (errors == 0) begin
      $display("chained_hash_table_unit regression: pass");
    end else begin
      $display("chained_hash_table_unit regression: fail");
    end
    $finish;
  end

endmodule
